// File: rtl/core/bf3em_pkg.sv
// Shared types, register codes and arithmetic helpers for the 3x3 edge-mean box filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package bf3em_pkg;

  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 12;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RST = 12'd480;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int QUEUE_DEPTH   = 8;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int PIX_W       = 8;
  localparam int COL_W       = 10;
  localparam int PAIR_W      = 9;
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int DIV_W = 2;
  localparam logic [DIV_W-1:0] DIV4 = 2'd0;
  localparam logic [DIV_W-1:0] DIV6 = 2'd1;
  localparam logic [DIV_W-1:0] DIV9 = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_slot_t;

  function automatic logic [COL_W-1:0] col_sum(input logic top, input logic [PIX_W-1:0] a0,
                                               input logic [PIX_W-1:0] a1,
                                               input logic [PIX_W-1:0] a2);
    return COL_W'(a1) + COL_W'(a2) + (top ? COL_W'(a0) : COL_W'(0));
  endfunction

  // fixed-point reciprocal, exact after the shift for sums below 2^15
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] div);
    logic [RECIP_W-1:0] r;
    case (div)
      DIV4:    r = 15'd16384;
      DIV6:    r = 15'd10923;
      DIV9:    r = 15'd7282;
      default: r = 15'd16384;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/box_filter_3x3_edge_mean.sv
// Top level of the 3x3 edge-mean box filter: counters, two line memories, sum and divide stages.
// Depends on bf3em_pkg and bf3em_out_queue.
//
// Usage: pixels enter in raster order on the in_valid/in_ready channel (opcode push). Each
// output pixel is the truncated mean of its in-image 3x3 neighbourhood and leaves on the
// out_valid/out_ready channel in raster order, with row_end and frame_end marks. An output
// appears once the pixel below and to the right of it has arrived; after the last pixel
// of the frame, one drain transaction per pixel flushes the final row. Pushes during the
// drain and drains before it are taken and dropped.
// Throughput: one transaction per cycle while in_ready is high, set by the single read and
// write port of each line memory (one read-modify-write per pixel). A result passes through
// the stage 1, 2 and 3 registers and then the result queue before it reaches the output.
// Configuration: cfg_wr_en writes image_width (index 0) or image_height (index 1) at once and
// restarts the frame; write only while the block is idle.
// Reset: counters return to the start of a frame, width 640, height 480; the line memories
// are not cleared. in_ready drops once queued plus in-flight results exceed OUT_DEPTH - 2.
`default_nettype none

module box_filter_3x3_edge_mean
  import bf3em_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int OUT_DEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int WCMP  = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
  localparam int QCW   = $clog2(OUT_DEPTH + 1);
  localparam int RSV_W = QCW + 2;

  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;

  logic [WCMP-1:0]       width_ext;
  logic [WCMP-1:0]       width_clamped;
  logic [WCMP-1:0]       width_last_ext;
  logic [AW-1:0]         w_last;
  logic [IMG_H_BITS-1:0] h_eff;
  logic [IMG_H_BITS-1:0] h_last;

  logic [AW-1:0]         column_count;
  logic [IMG_H_BITS-1:0] row_count;
  logic [AW-1:0]         drain_count;

  logic          accept;
  logic          drain_phase;
  logic          issue_push;
  logic          issue_drain;
  logic          issue;
  logic          col_is_last;
  logic          drain_is_last;
  logic [AW-1:0] rd_addr;

  logic [PIX_W-1:0] upper_line  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] middle_rd;

  logic             s1_valid;
  logic             s1_drain;
  logic             s1_top;
  logic             s1_emit;
  logic             s1_three;
  logic             s1_endrow;
  logic             s1_cap;
  logic [PIX_W-1:0] s1_pix;
  logic [AW-1:0]    s1_addr;
  logic             s1_lo;
  logic             s1_hi;
  logic             s1_last;
  logic             s1_fwd;
  logic [1:0]       s1_nres;
  logic [PIX_W-1:0] fwd_upper;
  logic [PIX_W-1:0] fwd_middle;

  logic [PIX_W-1:0]  left_col [3];
  logic [PIX_W-1:0]  mid_col  [3];
  logic [PAIR_W-1:0] dp0;
  logic [PAIR_W-1:0] dp1;

  logic [PIX_W-1:0]  cur_up;
  logic [PIX_W-1:0]  cur_mid;
  logic              line_wr;
  logic [COL_W-1:0]  col_left;
  logic [COL_W-1:0]  col_midc;
  logic [COL_W-1:0]  col_cur;
  logic [SUM_W-1:0]  sum_two;
  logic [SUM_W-1:0]  sum_three;
  logic [PAIR_W-1:0] pair_new;
  logic [PAIR_W-1:0] pair_push;
  logic [SUM_W-1:0]  drain_sum;

  logic             s2_a_valid;
  logic             s2_b_valid;
  logic [SUM_W-1:0] s2_a_sum;
  logic [SUM_W-1:0] s2_b_sum;
  logic [DIV_W-1:0] s2_a_div;
  logic [DIV_W-1:0] s2_b_div;
  logic             s2_a_row_end;
  logic             s2_a_frame_end;

  logic              s3_a_valid;
  logic              s3_b_valid;
  logic [PROD_W-1:0] s3_a_prod;
  logic [PROD_W-1:0] s3_b_prod;
  logic              s3_a_row_end;
  logic              s3_a_frame_end;

  out_slot_t      wr_a;
  out_slot_t      wr_b;
  logic [QCW-1:0] q_fill;
  logic [2:0]     inflight;

  // effective frame size
  always_comb begin
    width_ext = WCMP'(image_width);
    if (width_ext < WCMP'(2)) begin
      width_clamped = WCMP'(2);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      width_clamped = WCMP'(MAX_WIDTH);
    end else begin
      width_clamped = width_ext;
    end
    width_last_ext = width_clamped - WCMP'(1);
    w_last         = width_last_ext[AW-1:0];
    h_eff          = (image_height < IMG_H_BITS'(2)) ? IMG_H_BITS'(2) : image_height;
    h_last         = h_eff - IMG_H_BITS'(1);
  end

  assign accept        = in_valid && in_ready;
  assign drain_phase   = (row_count >= h_eff);
  assign issue_push    = accept && !drain_phase && (in_data.opcode == OP_PUSH);
  assign issue_drain   = accept && drain_phase && (in_data.opcode == OP_DRAIN);
  assign issue         = issue_push || issue_drain;
  assign col_is_last   = (column_count == w_last);
  assign drain_is_last = (drain_count == w_last);
  assign rd_addr       = issue_drain ? (drain_is_last ? drain_count : drain_count + AW'(1))
                                     : column_count;

  assign inflight = 3'(s1_nres) + 3'(s2_a_valid) + 3'(s2_b_valid)
                  + 3'(s3_a_valid) + 3'(s3_b_valid);
  assign in_ready = (RSV_W'(q_fill) + RSV_W'(inflight)) <= RSV_W'(OUT_DEPTH - 2);

  // configuration and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else if (issue_push) begin
      if (col_is_last) begin
        column_count <= '0;
        row_count    <= row_count + IMG_H_BITS'(1);
        drain_count  <= '0;
      end else begin
        column_count <= column_count + AW'(1);
      end
    end else if (issue_drain) begin
      if (drain_is_last) begin
        column_count <= '0;
        row_count    <= '0;
        drain_count  <= '0;
      end else begin
        drain_count <= drain_count + AW'(1);
      end
    end
  end

  // line memories: read at accept, write back in the cycle after
  always_ff @(posedge clk) begin
    upper_rd  <= upper_line[rd_addr];
    middle_rd <= middle_line[rd_addr];
    if (line_wr) begin
      upper_line[s1_addr]  <= cur_mid;
      middle_line[s1_addr] <= s1_pix;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_nres  <= '0;
    end else begin
      s1_valid <= issue;
      if (issue_drain) begin
        s1_nres <= 2'd1;
      end else if (issue_push) begin
        s1_nres <= 2'(row_count != '0 && column_count != '0)
                 + 2'(row_count != '0 && col_is_last);
      end else begin
        s1_nres <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_drain   <= issue_drain;
    s1_top     <= (row_count >= IMG_H_BITS'(2));
    s1_emit    <= (row_count != '0) && (column_count != '0);
    s1_three   <= (column_count >= AW'(2));
    s1_endrow  <= (row_count != '0) && col_is_last;
    s1_cap     <= (row_count == h_last) && (column_count == '0);
    s1_pix     <= in_data.pixel_in;
    s1_addr    <= column_count;
    s1_lo      <= (drain_count != '0);
    s1_hi      <= !drain_is_last;
    s1_last    <= drain_is_last;
    s1_fwd     <= line_wr && issue && (rd_addr == s1_addr);
    fwd_upper  <= cur_mid;
    fwd_middle <= s1_pix;
  end

  // stage 1: window sums
  always_comb begin
    cur_up    = s1_fwd ? fwd_upper : upper_rd;
    cur_mid   = s1_fwd ? fwd_middle : middle_rd;
    line_wr   = s1_valid && !s1_drain;
    col_left  = col_sum(s1_top, left_col[0], left_col[1], left_col[2]);
    col_midc  = col_sum(s1_top, mid_col[0], mid_col[1], mid_col[2]);
    col_cur   = col_sum(s1_top, cur_up, cur_mid, s1_pix);
    sum_two   = SUM_W'(col_midc) + SUM_W'(col_cur);
    sum_three = sum_two + (s1_three ? SUM_W'(col_left) : SUM_W'(0));
    pair_new  = PAIR_W'(cur_up) + PAIR_W'(cur_mid);
    pair_push = PAIR_W'(cur_mid) + PAIR_W'(s1_pix);
    drain_sum = (s1_lo ? SUM_W'(dp0) : SUM_W'(0)) + SUM_W'(dp1)
              + (s1_hi ? SUM_W'(pair_new) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (line_wr) begin
      left_col <= mid_col;
      mid_col  <= '{cur_up, cur_mid, s1_pix};
      if (s1_cap) begin
        dp1 <= pair_push;
      end
    end else if (s1_valid) begin
      dp0 <= dp1;
      dp1 <= pair_new;
    end
  end

  // stage 2: sums and divisors
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_a_valid <= 1'b0;
      s2_b_valid <= 1'b0;
    end else begin
      s2_a_valid <= s1_valid && (s1_drain || s1_emit);
      s2_b_valid <= s1_valid && !s1_drain && s1_endrow;
    end
  end

  always_ff @(posedge clk) begin
    s2_b_sum <= sum_two;
    s2_b_div <= s1_top ? DIV6 : DIV4;
    if (s1_drain) begin
      s2_a_sum       <= drain_sum;
      s2_a_div       <= (s1_lo && s1_hi) ? DIV6 : DIV4;
      s2_a_row_end   <= s1_last;
      s2_a_frame_end <= s1_last;
    end else begin
      s2_a_sum       <= sum_three;
      s2_a_div       <= s1_three ? (s1_top ? DIV9 : DIV6) : (s1_top ? DIV6 : DIV4);
      s2_a_row_end   <= 1'b0;
      s2_a_frame_end <= 1'b0;
    end
  end

  // stage 3: reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_a_valid <= 1'b0;
      s3_b_valid <= 1'b0;
    end else begin
      s3_a_valid <= s2_a_valid;
      s3_b_valid <= s2_b_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_a_prod      <= PROD_W'(s2_a_sum) * PROD_W'(recip(s2_a_div));
    s3_b_prod      <= PROD_W'(s2_b_sum) * PROD_W'(recip(s2_b_div));
    s3_a_row_end   <= s2_a_row_end;
    s3_a_frame_end <= s2_a_frame_end;
  end

  always_comb begin
    wr_a.valid          = s3_a_valid;
    wr_a.item.pixel_out = s3_a_prod[RECIP_SHIFT +: PIX_W];
    wr_a.item.row_end   = s3_a_row_end;
    wr_a.item.frame_end = s3_a_frame_end;
    wr_b.valid          = s3_b_valid;
    wr_b.item.pixel_out = s3_b_prod[RECIP_SHIFT +: PIX_W];
    wr_b.item.row_end   = 1'b1;
    wr_b.item.frame_end = 1'b0;
  end

  bf3em_out_queue #(
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_a      (wr_a),
    .wr_b      (wr_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fill      (q_fill)
  );

endmodule

`default_nettype wire

// File: rtl/core/bf3em_out_queue.sv
// Result queue of the box filter: takes up to two results a cycle, hands out one.
// Depends on bf3em_pkg for the result types.
`default_nettype none

module bf3em_out_queue
  import bf3em_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  out_slot_t                  wr_a,
  input  out_slot_t                  wr_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  output logic [$clog2(DEPTH+1)-1:0] fill
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t entries [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] tail_b;
  logic [PW-1:0] tail_next;
  logic          pop;
  logic [1:0]    n_wr;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? PW'(0) : p + PW'(1);
  endfunction

  assign out_valid = (fill != CW'(0));
  assign out_data  = entries[head];
  assign pop       = out_valid && out_ready;
  assign tail_b    = wr_a.valid ? inc(tail) : tail;
  assign tail_next = wr_b.valid ? inc(tail_b) : tail_b;
  assign n_wr      = 2'(wr_a.valid) + 2'(wr_b.valid);

  always_ff @(posedge clk) begin
    if (wr_a.valid) begin
      entries[tail] <= wr_a.item;
    end
    if (wr_b.valid) begin
      entries[tail_b] <= wr_b.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail_next;
      if (pop) begin
        head <= inc(head);
      end
      fill <= fill + CW'(n_wr) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// File: dv/box_filter_3x3_edge_mean_tb.sv
// Self-checking testbench for box_filter_3x3_edge_mean: drives pixel and drain transactions,
// predicts every edge-aware 3x3 mean and compares each output field as it leaves the block.
// Depends on bf3em_pkg and the RTL of box_filter_3x3_edge_mean only.
module box_filter_3x3_edge_mean_tb;
  import bf3em_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LINE_LEN     = DEF_MAX_WIDTH;
  localparam int          SETTLE_WAIT  = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned TALL_ITEMS   = 40;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  // filter state as seen from outside
  bit [7:0]  row_above [LINE_LEN];
  bit [7:0]  row_mid [LINE_LEN];
  bit [7:0]  win [6];
  bit [10:0] col_pos   = '0;
  bit [11:0] row_pos   = '0;
  bit [10:0] drain_pos = '0;
  bit [10:0] cfg_width  = IMAGE_WIDTH_RST;
  bit [11:0] cfg_height = IMAGE_HEIGHT_RST;

  out_item_t   pending_means [$];
  int unsigned mismatches      = 0;
  int unsigned effective_items = 0;
  int unsigned hold_left       = 0;
  int unsigned cycle_count     = 0;
  bit          in_gaps         = 1'b1;
  bit          out_gaps        = 1'b1;

  box_filter_3x3_edge_mean dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > LINE_LEN) return LINE_LEN;
    return cfg_width;
  endfunction

  function automatic int unsigned active_height();
    if (cfg_height < 2) return 2;
    return cfg_height;
  endfunction

  function automatic int unsigned column_total(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c, input logic top);
    return 32'(b) + 32'(c) + (top ? 32'(a) : 32'd0);
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic restart_frame();
    col_pos   = '0;
    row_pos   = '0;
    drain_pos = '0;
  endtask

  task automatic expect_mean(input int unsigned total, input int unsigned count,
                             input logic last_in_row, input logic last_in_frame);
    out_item_t m;
    m.pixel_out = 8'(total / count);
    m.row_end   = last_in_row;
    m.frame_end = last_in_frame;
    pending_means.push_back(m);
  endtask

  task automatic predict_means(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned w, h, lo, hi, x, total, rows, c, r, k;
    logic        top;
    logic [7:0]  cur [3];
    w = active_width();
    h = active_height();
    if (col_pos >= w || drain_pos >= w || row_pos > h) restart_frame();
    if (row_pos >= h) begin
      if (op == OP_DRAIN) begin
        lo = (drain_pos > 0) ? drain_pos - 1 : 0;
        hi = (drain_pos + 1 < w) ? drain_pos + 1 : w - 1;
        total = 0;
        for (x = lo; x <= hi; x++) total += 32'(row_above[x]) + 32'(row_mid[x]);
        expect_mean(total, 2 * (hi - lo + 1), drain_pos == w - 1, drain_pos == w - 1);
        drain_pos++;
        if (drain_pos >= w) restart_frame();
      end
    end else if (op == OP_PUSH) begin
      c = col_pos;
      r = row_pos;
      top = (r >= 2);
      rows = top ? 3 : 2;
      cur[0] = row_above[c];
      cur[1] = row_mid[c];
      cur[2] = pix;
      row_above[c] = cur[1];
      row_mid[c] = pix;
      total = column_total(win[3], win[4], win[5], top) +
              column_total(cur[0], cur[1], cur[2], top);
      if (r >= 1 && c >= 1) begin
        if (c >= 2) expect_mean(total + column_total(win[0], win[1], win[2], top),
                                3 * rows, 1'b0, 1'b0);
        else expect_mean(total, 2 * rows, 1'b0, 1'b0);
      end
      if (r >= 1 && c == w - 1) expect_mean(total, 2 * rows, 1'b1, 1'b0);
      for (k = 0; k < 3; k++) begin
        win[k] = win[k + 3];
        win[k + 3] = cur[k];
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        drain_pos = '0;
      end
      col_pos = c;
      row_pos = r;
    end
  endtask

  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
    in_item_t item;
    item.opcode   = op;
    item.pixel_in = pix;
    if (in_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predict_means(op, pix);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) cfg_width = value[10:0];
    else cfg_height = value;
    restart_frame();
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] raw_w, input logic [CFG_DATA_W-1:0] raw_h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, raw_w);
    write_reg(REG_IMAGE_HEIGHT, raw_h);
  endtask

  // stop_at of zero runs the whole frame including its drain
  task automatic run_frame(input int unsigned stop_at);
    int unsigned area, full, n;
    area = active_width() * active_height();
    full = area + active_width();
    if (stop_at == 0 || stop_at > full) stop_at = full;
    n = 0;
    while (n < stop_at) begin
      if ($urandom_range(99) < 6) begin
        send_item((n < area) ? OP_DRAIN : OP_PUSH, 8'($urandom_range(255)));
      end else begin
        send_item((n < area) ? OP_PUSH : OP_DRAIN, pick_pixel());
        n++;
        effective_items++;
      end
    end
  endtask

  task automatic check_mean(input out_item_t got);
    out_item_t want;
    if (pending_means.size() == 0) begin
      $error("unexpected transaction: pixel_out %0d row_end %0b frame_end %0b",
             got.pixel_out, got.row_end, got.frame_end);
      mismatches++;
    end else begin
      want = pending_means.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
        mismatches++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, got.frame_end);
        mismatches++;
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_mean(out_data);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(out_gaps && $urandom_range(99) < 14);
      end
    end
  end

  task automatic test_small_frames();
    int unsigned i;
    configure(12'd3, 12'd3);
    send_item(OP_PUSH, 8'd0);
    send_item(OP_PUSH, 8'd255);
    send_item(OP_PUSH, 8'd255);
    send_item(OP_PUSH, 8'd0);
    // restart mid frame
    configure(12'd3, 12'd3);
    send_item(OP_DRAIN, 8'd255);
    for (i = 0; i < 9; i++) send_item(OP_PUSH, (i % 2 == 0) ? 8'd255 : 8'd0);
    send_item(OP_PUSH, 8'd7);
    repeat (3) send_item(OP_DRAIN, 8'd0);
    // width above 11 bits and both sizes below the minimum
    configure(12'h801, 12'd0);
    repeat (4) send_item(OP_PUSH, 8'd255);
    repeat (2) send_item(OP_DRAIN, 8'd0);
  endtask

  task automatic test_random_frames();
    int unsigned start, total, stop_at;
    logic [CFG_DATA_W-1:0] raw_w, raw_h;
    start = effective_items;
    while (effective_items - start < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: raw_w = CFG_DATA_W'($urandom_range(1));
        1: raw_w = CFG_DATA_W'($urandom_range(40, 13));
        default: raw_w = CFG_DATA_W'($urandom_range(12, 2));
      endcase
      if ($urandom_range(9) == 0) raw_h = CFG_DATA_W'($urandom_range(1));
      else raw_h = CFG_DATA_W'($urandom_range(7, 2));
      configure(raw_w, raw_h);
      in_gaps  = ($urandom_range(5) != 0);
      out_gaps = ($urandom_range(5) != 0);
      total = active_width() * active_height() + active_width();
      stop_at = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : 0;
      run_frame(stop_at);
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    configure(12'd12, 12'd6);
    // hold the receiver off so the result queue fills and input stalls
    hold_left = 300;
    run_frame(0);
  endtask

  task automatic test_back_to_back();
    configure(12'd16, 12'd8);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    run_frame(0);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_extreme_sizes();
    configure(12'd2, 12'd4095);
    run_frame(TALL_ITEMS);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_frames();
    test_random_frames();
    test_backpressure();
    test_back_to_back();
    test_extreme_sizes();
    wait_idle();
    if (mismatches == 0 && pending_means.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
